>>> hw/rtl/rbsi_pkg.sv
// Shared constants and types for the ray versus box slab intersection unit.
// Used by the configuration registers, the divider pipeline and the top level.
package rbsi_pkg;

    localparam int DIR_W    = 32;
    localparam int DIR_FRAC = 30;
    localparam int REM_W    = 32;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    typedef struct packed {
        logic neg;
        logic dzero;
        logic nzero;
        logic npos;
    } t_div_flags;

endpackage

>>> hw/rtl/ray_box_slab_intersect_unit.sv
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbsi_pkg, rbsi_cfg and rbsi_div.
//
//   channel  | direction | handshake           | payload
//   ray in   | input     | i_valid / o_stall   | i_origin_*, i_dir_*
//   result   | output    | o_valid / i_stall   | o_hit, o_t_enter, o_t_exit
//   config   | input     | APB psel / penable  | paddr, pwdata, prdata
//
// One item is accepted per cycle while o_stall is low.
// Most of the pipeline depth lies in the six parallel dividers, each producing one quotient bit per stage.
// Reset clears the valid bits and loads the default unit box.
// A stall at the output while o_valid is high freezes the whole pipeline and raises o_stall in the same cycle.
module ray_box_slab_intersect_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [COORD_WIDTH-1:0]        i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]        i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]        i_origin_z,
    input  logic signed [rbsi_pkg::DIR_W-1:0]    i_dir_x,
    input  logic signed [rbsi_pkg::DIR_W-1:0]    i_dir_y,
    input  logic signed [rbsi_pkg::DIR_W-1:0]    i_dir_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    output logic signed [COORD_WIDTH-1:0]        o_t_enter,
    output logic signed [COORD_WIDTH-1:0]        o_t_exit,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0]  paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                 pready
);
    localparam int CW  = COORD_WIDTH;
    localparam int LAT = CW + 5;

    logic signed [CW-1:0] box_min [3];
    logic signed [CW-1:0] box_max [3];
    logic signed [CW-1:0] org     [3];
    logic signed [rbsi_pkg::DIR_W-1:0] dir [3];
    logic signed [CW-1:0] t_lo    [3];
    logic signed [CW-1:0] t_hi    [3];
    logic signed [CW-1:0] r_near  [3];
    logic signed [CW-1:0] r_far   [3];
    logic signed [CW-1:0] r_enter;
    logic signed [CW-1:0] r_exit;
    logic signed [CW-1:0] n_enter;
    logic signed [CW-1:0] n_exit;
    logic [LAT-1:0]       r_vld;
    logic                 en;

    rbsi_cfg #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_box_min (box_min),
        .o_box_max (box_max)
    );

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;
    assign org[0]  = i_origin_x;
    assign org[1]  = i_origin_y;
    assign org[2]  = i_origin_z;
    assign dir[0]  = i_dir_x;
    assign dir[1]  = i_dir_y;
    assign dir[2]  = i_dir_z;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [CW:0] n_lo;
        logic signed [CW:0] n_hi;
        assign n_lo = (CW+1)'(box_min[a]) - (CW+1)'(org[a]);
        assign n_hi = (CW+1)'(box_max[a]) - (CW+1)'(org[a]);

        rbsi_div #(.CW(CW)) u_div_lo (
            .i_clk (i_clk), .i_en (en), .i_num (n_lo), .i_den (dir[a]), .o_t (t_lo[a])
        );
        rbsi_div #(.CW(CW)) u_div_hi (
            .i_clk (i_clk), .i_en (en), .i_num (n_hi), .i_den (dir[a]), .o_t (t_hi[a])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_near[a] <= (t_lo[a] < t_hi[a]) ? t_lo[a] : t_hi[a];
                r_far[a]  <= (t_lo[a] < t_hi[a]) ? t_hi[a] : t_lo[a];
            end
        end
    end

    always_comb begin
        n_enter = r_near[0];
        n_exit  = r_far[0];
        if (r_near[1] > n_enter) n_enter = r_near[1];
        if (r_near[2] > n_enter) n_enter = r_near[2];
        if (r_far[1] < n_exit)   n_exit  = r_far[1];
        if (r_far[2] < n_exit)   n_exit  = r_far[2];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_enter   <= n_enter;
            r_exit    <= n_exit;
            o_t_enter <= r_enter;
            o_t_exit  <= r_exit;
            o_hit     <= !r_exit[CW-1] && !(r_enter > r_exit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[LAT-1];

endmodule

>>> hw/rtl/rbsi_cfg.sv
// Box corner registers behind an APB-style port.
// Depends on rbsi_pkg for the register indexes.
module rbsi_cfg #(
    parameter int CW        = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [((CW > 32) ? 6 : 5)-1:0] paddr,
    input  logic [((CW > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((CW > 32) ? 64 : 32)-1:0] prdata,
    output logic                          pready,
    output logic signed [CW-1:0]          o_box_min [3],
    output logic signed [CW-1:0]          o_box_max [3]
);
    localparam int PW = (CW > 32) ? 64 : 32;
    localparam int AW = (CW > 32) ? 6 : 5;
    localparam int SH = (CW > 32) ? 3 : 2;
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    logic signed [CW-1:0] r_min [3];
    logic signed [CW-1:0] r_max [3];
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[AW-1:SH];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= -ONE;
                r_max[a] <= ONE;
            end
        end else if (wr) begin
            unique case (idx)
                rbsi_pkg::REG_MIN_X: r_min[0] <= pwdata[CW-1:0];
                rbsi_pkg::REG_MIN_Y: r_min[1] <= pwdata[CW-1:0];
                rbsi_pkg::REG_MIN_Z: r_min[2] <= pwdata[CW-1:0];
                rbsi_pkg::REG_MAX_X: r_max[0] <= pwdata[CW-1:0];
                rbsi_pkg::REG_MAX_Y: r_max[1] <= pwdata[CW-1:0];
                rbsi_pkg::REG_MAX_Z: r_max[2] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rbsi_pkg::REG_MIN_X: prdata = PW'(r_min[0]);
            rbsi_pkg::REG_MIN_Y: prdata = PW'(r_min[1]);
            rbsi_pkg::REG_MIN_Z: prdata = PW'(r_min[2]);
            rbsi_pkg::REG_MAX_X: prdata = PW'(r_max[0]);
            rbsi_pkg::REG_MAX_Y: prdata = PW'(r_max[1]);
            rbsi_pkg::REG_MAX_Z: prdata = PW'(r_max[2]);
            default:             prdata = '0;
        endcase
    end

    assign o_box_min = r_min;
    assign o_box_max = r_max;

endmodule

>>> hw/rtl/rbsi_div.sv
// Pipelined plane distance unit: (num << 30) / den, truncated and saturated.
// One quotient bit per stage. Depends on rbsi_pkg.
module rbsi_div #(
    parameter int CW = 32
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [CW:0]             i_num,
    input  logic signed [rbsi_pkg::DIR_W-1:0] i_den,
    output logic signed [CW-1:0]           o_t
);
    localparam int DW = CW + 1 + rbsi_pkg::DIR_FRAC;
    localparam int RW = rbsi_pkg::REM_W;
    localparam logic [CW-1:0] T_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] T_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] T_NMAX = {1'b1, {(CW-2){1'b0}}, 1'b1};

    logic [DW-1:0]            r0_d;
    logic [RW-1:0]            r0_ud;
    rbsi_pkg::t_div_flags     r_fl  [0:CW];
    logic [RW-1:0]            r_ud  [1:CW-1];
    logic [RW-1:0]            r_rem [1:CW-1];
    logic [CW-2:0]            r_low [1:CW-1];
    logic [CW-2:0]            r_q   [1:CW];
    logic                     r_ovf [1:CW];
    logic [CW:0]              un;
    logic [RW-1:0]            ud;
    logic [RW-1:0]            top;

    assign un  = i_num[CW] ? (CW+1)'(-i_num) : i_num;
    assign ud  = i_den[rbsi_pkg::DIR_W-1] ? RW'(-i_den) : RW'(i_den);
    assign top = r0_d[DW-1:CW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_d        <= {un, {rbsi_pkg::DIR_FRAC{1'b0}}};
            r0_ud       <= ud;
            r_fl[0].neg   <= i_num[CW] ^ i_den[rbsi_pkg::DIR_W-1];
            r_fl[0].dzero <= (i_den == '0);
            r_fl[0].nzero <= (i_num == '0);
            r_fl[0].npos  <= !i_num[CW];
            r_fl[1]  <= r_fl[0];
            r_ud[1]  <= r0_ud;
            r_rem[1] <= top;
            r_low[1] <= r0_d[CW-2:0];
            r_q[1]   <= '0;
            r_ovf[1] <= (top >= r0_ud);
        end
    end

    for (genvar k = 1; k < CW; k++) begin : g_step
        logic [RW:0] sh;
        logic        ge;
        assign sh = {r_rem[k], r_low[k][CW-2]};
        assign ge = (sh >= {1'b0, r_ud[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_fl[k+1]  <= r_fl[k];
                r_ovf[k+1] <= r_ovf[k];
                r_q[k+1]   <= {r_q[k][CW-3:0], ge};
            end
        end
        if (k < CW-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ud[k+1]  <= r_ud[k];
                    r_rem[k+1] <= ge ? RW'(sh - {1'b0, r_ud[k]}) : sh[RW-1:0];
                    r_low[k+1] <= {r_low[k][CW-3:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_fl[CW].dzero) begin
                o_t <= r_fl[CW].nzero ? '0 : (r_fl[CW].npos ? T_MAX : T_NMAX);
            end else if (r_ovf[CW]) begin
                o_t <= r_fl[CW].neg ? T_MIN : T_MAX;
            end else begin
                o_t <= r_fl[CW].neg ? -{1'b0, r_q[CW]} : {1'b0, r_q[CW]};
            end
        end
    end

endmodule

>>> tb/ray_box_slab_intersect_unit_tb.sv
// Self-checking testbench for the ray versus axis-aligned box slab test unit.
// Drives rays and APB register writes, predicts each result and compares in order.
// Depends on rbsi_pkg and ray_box_slab_intersect_unit.
module ray_box_slab_intersect_unit_tb;

    localparam int CW = 32;
    localparam int LATENCY = CW + 5;
    localparam int MAX_CYCLES = 400000;
    localparam longint T_BIG = 64'sd2147483647;

    typedef struct {
        logic hit;
        logic [CW-1:0] t_enter;
        logic [CW-1:0] t_exit;
    } t_hit_result;

    class slab_scoreboard;
        logic [CW-1:0] box [6];
        t_hit_result pending [$];
        int mismatches;

        function new();
            mismatches = 0;
            box[rbsi_pkg::REG_MIN_X] = -32'sd65536;
            box[rbsi_pkg::REG_MIN_Y] = -32'sd65536;
            box[rbsi_pkg::REG_MIN_Z] = -32'sd65536;
            box[rbsi_pkg::REG_MAX_X] = 32'sd65536;
            box[rbsi_pkg::REG_MAX_Y] = 32'sd65536;
            box[rbsi_pkg::REG_MAX_Z] = 32'sd65536;
        endfunction

        function longint plane_dist(longint n, longint d);
            longint un, ud, q0, r0, q;
            bit neg;
            if (d == 0) return n > 0 ? T_BIG : (n < 0 ? -T_BIG : 0);
            un = n < 0 ? -n : n;
            ud = d < 0 ? -d : d;
            neg = (n < 0) != (d < 0);
            q0 = un / ud;
            r0 = un % ud;
            if (q0 > (T_BIG >>> rbsi_pkg::DIR_FRAC)) return neg ? -T_BIG - 1 : T_BIG;
            q = (q0 <<< rbsi_pkg::DIR_FRAC) + ((r0 <<< rbsi_pkg::DIR_FRAC) / ud);
            if (!neg) return q > T_BIG ? T_BIG : q;
            if (q > T_BIG) return -T_BIG - 1;
            return -q;
        endfunction

        function void note_ray(logic [CW-1:0] org [3], logic [31:0] dir [3]);
            longint enter, leave, t1, t2, nr, fr;
            t_hit_result r;
            enter = 0;
            leave = 0;
            for (int a = 0; a < 3; a++) begin
                t1 = plane_dist(longint'($signed(box[a])) - longint'($signed(org[a])),
                                longint'($signed(dir[a])));
                t2 = plane_dist(longint'($signed(box[a+3])) - longint'($signed(org[a])),
                                longint'($signed(dir[a])));
                nr = t1 < t2 ? t1 : t2;
                fr = t1 < t2 ? t2 : t1;
                if (a == 0 || nr > enter) enter = nr;
                if (a == 0 || fr < leave) leave = fr;
            end
            r.hit = !(leave < 0) && !(enter > leave);
            r.t_enter = enter[CW-1:0];
            r.t_exit = leave[CW-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic hit, logic [CW-1:0] te, logic [CW-1:0] tx);
            t_hit_result e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result hit=%0d", hit);
                return;
            end
            e = pending.pop_front();
            if (e.hit !== hit || e.t_enter !== te || e.t_exit !== tx) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp hit=%0d enter=%h exit=%h got hit=%0d enter=%h exit=%h",
                             e.hit, e.t_enter, e.t_exit, hit, te, tx);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0;
    logic o_stall, o_valid, o_hit, pready;
    logic signed [CW-1:0] i_origin_x = 0, i_origin_y = 0, i_origin_z = 0;
    logic signed [31:0] i_dir_x = 0, i_dir_y = 0, i_dir_z = 0;
    logic signed [CW-1:0] o_t_enter, o_t_exit;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;

    slab_scoreboard sb = new();
    int cycles = 0;
    bit calm = 0;

    ray_box_slab_intersect_unit dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_hit, o_t_enter, o_t_exit);
        i_stall <= !calm && ($urandom_range(99) < 12);
    end

    task automatic write_box(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val; penable <= 0;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.box[idx] = val;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_ray(logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] oz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        logic [CW-1:0] org [3];
        logic [31:0] dir [3];
        while (!calm && $urandom_range(99) < 12) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_origin_x <= ox; i_origin_y <= oy; i_origin_z <= oz;
        i_dir_x <= dx; i_dir_y <= dy; i_dir_z <= dz;
        org = '{ox, oy, oz};
        dir = '{dx, dy, dz};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_ray(org, dir);
    endtask

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(5))
            0: return 0;
            1: return 32'sh40000000;
            2: return -32'sh40000000;
            3: return $urandom;
            default: return $signed($urandom_range(32'h7FFFFFFF)) - 32'sh40000000 >>> 1 << 1;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return {{13{1'b0}}, 19'($urandom)} - 32'h0004_0000;
            2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return {{14{1'b0}}, 18'($urandom)} - 32'h0002_0000;
        endcase
    endfunction

    task automatic random_rays(int n);
        for (int k = 0; k < n; k++) begin
            if (k % 200 < 40) calm = 1; else calm = 0;
            send_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
                     rand_dir());
        end
        i_valid <= 0;
        calm = 0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_ray(0, 0, 0, 32'sh40000000, 0, 0);
        send_ray(32'sh00020000, 0, 0, -32'sh40000000, 0, 0);
        send_ray(32'sh00020000, 0, 0, 32'sh40000000, 0, 0);
        send_ray(0, 32'sh00020000, 0, 32'sh40000000, 0, 0);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1, -1, 32'hFFFFFFFF);
        send_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1);
        send_ray(0, 0, 0, 32'sh2D413CCD, 32'sh2D413CCD, 0);
        send_ray(32'h00010000, 0, 0, 0, 32'sh40000000, 0);
        i_valid <= 0;
        drain();
        random_rays(300);
        drain();
        // Swapped corners and extreme box.
        write_box(rbsi_pkg::REG_MIN_X, 32'h7FFFFFFF);
        write_box(rbsi_pkg::REG_MAX_X, 32'h80000000);
        write_box(rbsi_pkg::REG_MIN_Y, 32'h80000000);
        write_box(rbsi_pkg::REG_MAX_Y, 32'h7FFFFFFF);
        write_box(rbsi_pkg::REG_MIN_Z, 32'h00030000);
        write_box(rbsi_pkg::REG_MAX_Z, 32'hFFFD0000);
        send_ray(0, 0, 0, 32'sh40000000, 32'sh40000000, 32'sh40000000);
        send_ray(0, 0, 0, 0, 0, 0);
        i_valid <= 0;
        random_rays(300);
        drain();
        for (int r = 0; r < 6; r++) write_box(r[2:0], rand_coord());
        random_rays(350);
        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> ray_box_slab_intersect_unit.f
hw/rtl/rbsi_pkg.sv
hw/rtl/rbsi_cfg.sv
hw/rtl/rbsi_div.sv
hw/rtl/ray_box_slab_intersect_unit.sv
tb/ray_box_slab_intersect_unit_tb.sv
